// ===== rtl/lcd4_pkg.sv =====
// Shared types and constants for the two-panel 4-bit character LCD sequencer.
// Used by every module in rtl/; no dependencies.
package lcd4_pkg;

   // request kinds as carried in req_tuser
   localparam logic [2:0] REQ_TICK   = 3'd0;
   localparam logic [2:0] REQ_CMD    = 3'd1;
   localparam logic [2:0] REQ_DATA   = 3'd2;
   localparam logic [2:0] REQ_CURSOR = 3'd3;
   localparam logic [2:0] REQ_INIT   = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_ENABLE_HIGH = 2'd0;
   localparam logic [1:0] CSR_ENABLE_LOW  = 2'd1;
   localparam logic [1:0] CSR_READ_LOW    = 2'd2;
   localparam logic [1:0] CSR_POLL_LIMIT  = 2'd3;

   localparam logic [7:0]  ENABLE_HIGH_RESET = 8'd5;
   localparam logic [7:0]  ENABLE_LOW_RESET  = 8'd1;
   localparam logic [7:0]  READ_LOW_RESET    = 8'd5;
   localparam logic [15:0] POLL_LIMIT_RESET  = 16'd4095;

   localparam logic [7:0] CURSOR_LINE0 = 8'h80;
   localparam logic [3:0] CURSOR_LINE1 = 4'hC;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_POLL,
      KIND_INIT,
      KIND_NONE
   } kind_type;

   // one classified word passed from front to back
   typedef struct packed {
      kind_type   kind;
      logic       panel;
      logic [7:0] byte_val;
      logic       rs;
      logic       d7;
   } item_type;

   typedef struct packed {
      logic [7:0]  enable_high;
      logic [7:0]  enable_low;
      logic [7:0]  read_low;
      logic [15:0] poll_limit;
   } cfg_type;

endpackage

// ===== rtl/lcd4_front.sv =====
// Front end: unpacks a request word and classifies it for the sequencer.
// Depends on lcd4_pkg.
module lcd4_front (
   input  logic [2:0]                      req_type,
   input  logic [lcd4_pkg::REQ_DATA_W-1:0] req_data,
   output lcd4_pkg::item_type              item
);
   import lcd4_pkg::*;

   logic       panel;
   logic [7:0] value;
   logic       line;
   logic [4:0] column;
   logic [3:0] bus_in;

   assign panel  = req_data[0];
   assign value  = req_data[8:1];
   assign line   = req_data[9];
   assign column = req_data[14:10];
   assign bus_in = req_data[18:15];

   always_comb begin
      item.panel    = panel;
      item.byte_val = value;
      item.rs       = 1'b0;
      item.d7       = bus_in[3];
      item.kind     = KIND_NONE;
      unique case (req_type)
         REQ_TICK: begin
            item.kind = KIND_TICK;
         end
         REQ_CMD: begin
            item.kind = KIND_POLL;
         end
         REQ_DATA: begin
            item.kind = KIND_POLL;
            item.rs   = 1'b1;
         end
         REQ_CURSOR: begin
            item.kind = KIND_POLL;
            if (line) begin
               item.byte_val = {CURSOR_LINE1, column[3:0]};
            end else begin
               item.byte_val = CURSOR_LINE0 | {3'b000, column};
            end
         end
         REQ_INIT: begin
            item.kind     = KIND_INIT;
            item.byte_val = {4'h0, value[3:0]};
         end
         default: begin
            item.kind = KIND_NONE;
         end
      endcase
   end

endmodule

// ===== rtl/lcd4_queue.sv =====
// Two-entry queue of classified words between front end and sequencer.
// Depends on lcd4_pkg.
module lcd4_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  lcd4_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output lcd4_pkg::item_type out_item
);
   import lcd4_pkg::*;

   item_type   mem [0:1];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = mem[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ===== rtl/lcd4_back.sv =====
// Back end: pin sequencer for busy polling and nibble strobes, with the
// registered result word. Depends on lcd4_pkg.
module lcd4_back (
   input  logic                            clock,
   input  logic                            reset,
   input  lcd4_pkg::cfg_type               cfg,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  lcd4_pkg::item_type              in_item,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [lcd4_pkg::RSP_DATA_W-1:0] out_data
);
   import lcd4_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RH_HI,
      PH_RH_LO,
      PH_RL_HI,
      PH_RL_LO,
      PH_WH_HI,
      PH_WH_LO,
      PH_WL_HI,
      PH_WL_LO
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  tick_ff, tick_in;
   logic [15:0] polls_ff, polls_in;
   logic [7:0]  byte_ff, byte_in;
   logic        rs_ff, rs_in;
   logic        panel_ff, panel_in;
   logic        busy_ff, busy_in;
   logic        tout_ff, tout_in;
   logic        out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic       fire;
   logic       rej;
   logic [7:0] len_raw, len;
   logic       en, rs_pin, rw_pin, drive;
   logic [3:0] dout;

   assign in_ready  = !out_valid_ff || out_ready;
   assign fire      = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      unique case (phase_ff)
         PH_RH_LO, PH_RL_LO: len_raw = cfg.read_low;
         PH_WH_LO, PH_WL_LO: len_raw = cfg.enable_low;
         default:            len_raw = cfg.enable_high;
      endcase
      // a zero duration counts as one tick
      len = (len_raw == 8'd0) ? 8'd1 : len_raw;
   end

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      polls_in = polls_ff;
      byte_in  = byte_ff;
      rs_in    = rs_ff;
      panel_in = panel_ff;
      busy_in  = busy_ff;
      tout_in  = tout_ff;
      rej      = 1'b0;
      unique case (in_item.kind)
         KIND_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (tick_ff < len) begin
                  tick_in = tick_ff + 8'd1;
               end else begin
                  tick_in = 8'd1;
                  unique case (phase_ff)
                     PH_RH_HI: begin
                        busy_in  = in_item.d7;
                        phase_in = PH_RH_LO;
                     end
                     PH_RH_LO: phase_in = PH_RL_HI;
                     PH_RL_HI: phase_in = PH_RL_LO;
                     PH_RL_LO: begin
                        if (busy_ff && polls_ff != 16'd0) begin
                           polls_in = polls_ff - 16'd1;
                           phase_in = PH_RH_HI;
                        end else begin
                           if (busy_ff) begin
                              tout_in = 1'b1;
                           end
                           phase_in = PH_WH_HI;
                        end
                     end
                     PH_WH_HI: phase_in = PH_WH_LO;
                     PH_WH_LO: phase_in = PH_WL_HI;
                     PH_WL_HI: phase_in = PH_WL_LO;
                     default: begin
                        phase_in = PH_IDLE;
                        tick_in  = 8'd0;
                     end
                  endcase
               end
            end
         end
         KIND_POLL, KIND_INIT: begin
            if (phase_ff != PH_IDLE) begin
               rej = 1'b1;
            end else begin
               panel_in = in_item.panel;
               byte_in  = in_item.byte_val;
               rs_in    = in_item.rs;
               tick_in  = 8'd1;
               if (in_item.kind == KIND_INIT) begin
                  phase_in = PH_WL_HI;
               end else begin
                  polls_in = cfg.poll_limit;
                  busy_in  = 1'b0;
                  tout_in  = 1'b0;
                  phase_in = PH_RH_HI;
               end
            end
         end
         default: begin
            rej = 1'b0;
         end
      endcase
   end

   // pin levels after this word
   always_comb begin
      en     = 1'b0;
      rs_pin = 1'b0;
      rw_pin = 1'b0;
      dout   = 4'h0;
      drive  = 1'b1;
      unique case (phase_in)
         PH_RH_HI, PH_RL_HI: begin
            rw_pin = 1'b1; dout = 4'hF; drive = 1'b0; en = 1'b1;
         end
         PH_RH_LO, PH_RL_LO: begin
            rw_pin = 1'b1; dout = 4'hF; drive = 1'b0;
         end
         PH_WH_HI: begin
            rs_pin = rs_in; dout = byte_in[7:4]; en = 1'b1;
         end
         PH_WH_LO: begin
            rs_pin = rs_in; dout = byte_in[7:4];
         end
         PH_WL_HI: begin
            rs_pin = rs_in; dout = byte_in[3:0]; en = 1'b1;
         end
         PH_WL_LO: begin
            rs_pin = rs_in; dout = byte_in[3:0];
         end
         default: begin
            drive = 1'b1;
         end
      endcase
      out_data_in = {4'h0, tout_in, rej, (phase_in == PH_IDLE), drive, dout,
                     rw_pin, rs_pin, en && panel_in, en && !panel_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= 8'd0;
         polls_ff     <= 16'd0;
         byte_ff      <= 8'd0;
         rs_ff        <= 1'b0;
         panel_ff     <= 1'b0;
         busy_ff      <= 1'b0;
         tout_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         out_data_ff  <= '0;
      end else begin
         if (fire) begin
            phase_ff    <= phase_in;
            tick_ff     <= tick_in;
            polls_ff    <= polls_in;
            byte_ff     <= byte_in;
            rs_ff       <= rs_in;
            panel_ff    <= panel_in;
            busy_ff     <= busy_in;
            tout_ff     <= tout_in;
            out_data_ff <= out_data_in;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== rtl/char_lcd_4bit_sequencer.sv =====
// Top level of the two-panel 4-bit character LCD sequencer: config registers,
// front end, word queue and pin sequencer. Depends on lcd4_pkg and all rtl/ modules.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------------
//   req_     | in        | tvalid / tready    | tuser: req_type, tdata: request
//   rsp_     | out       | tvalid / tready    | tdata: pin levels and status
//   csr_     | in        | valid / ready      | index, data (ready tied high)
//
// One word is taken per clock while req_tready is high; a result word passes through the
// queue entry and then the sequencer's result register.
// Reset loads the register defaults, empties the queue and idles the pins.
// A stalled rsp_ side fills the two-entry queue, after which req_tready drops.
module char_lcd_4bit_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [0] panel, [8:1] value, [9] line, [14:10] column, [18:15] bus_in, rest zero
   input  logic [lcd4_pkg::REQ_DATA_W-1:0] req_tdata,
   // [2:0] req_type
   input  logic [2:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] enable_operator, [1] enable_customer, [2] reg_select,
   // [3] read_not_write, [7:4] bus_out, [8] bus_drive, [9] idle,
   // [10] rejected, [11] timed_out, rest zero
   output logic [lcd4_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [15:0]                     csr_data
);
   import lcd4_pkg::*;

   cfg_type  cfg_ff;
   item_type front_item;
   item_type queue_item;
   logic     queue_valid;
   logic     back_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_high <= ENABLE_HIGH_RESET;
         cfg_ff.enable_low  <= ENABLE_LOW_RESET;
         cfg_ff.read_low    <= READ_LOW_RESET;
         cfg_ff.poll_limit  <= POLL_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ENABLE_HIGH: cfg_ff.enable_high <= csr_data[7:0];
            CSR_ENABLE_LOW:  cfg_ff.enable_low  <= csr_data[7:0];
            CSR_READ_LOW:    cfg_ff.read_low    <= csr_data[7:0];
            CSR_POLL_LIMIT:  cfg_ff.poll_limit  <= csr_data;
            default:         cfg_ff.poll_limit  <= cfg_ff.poll_limit;
         endcase
      end
   end

   lcd4_front u_front (
      .req_type (req_tuser),
      .req_data (req_tdata),
      .item     (front_item)
   );

   lcd4_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (back_ready),
      .out_item  (queue_item)
   );

   lcd4_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (queue_valid),
      .in_ready  (back_ready),
      .in_item   (queue_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   // at most one panel strobed at a time
   a_one_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("both panel enables high");

   // pins are released whenever RW is high
   a_read_released: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3]) |-> (!rsp_tdata[8] && rsp_tdata[7:4] == 4'hF))
      else $error("bus driven during busy read");

   // an idle result shows quiet pins
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[9]) |->
         (rsp_tdata[3:0] == 4'h0 && rsp_tdata[7:4] == 4'h0 && rsp_tdata[8]))
      else $error("pins active while idle");

   // a rejected request never reports idle
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[10]) |-> !rsp_tdata[9])
      else $error("rejected while idle");

endmodule

// ===== tb/sv/tb_char_lcd_4bit_sequencer.sv =====
// Self-checking bench for char_lcd_4bit_sequencer: it drives request words with random
// idling and predicts the pin levels for each word. It checks every response word
// against the prediction. Depends on lcd4_pkg and the rtl/ modules.
module tb_char_lcd_4bit_sequencer;
   import lcd4_pkg::*;

   localparam int          QUIET_LIMIT = 2000;
   localparam int unsigned BUSY_PCT    = 20;
   localparam logic [2:0]  REQ_UNUSED_LO = 3'd5;
   localparam logic [2:0]  REQ_UNUSED_HI = 3'd7;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_RH_HI,
      SEQ_RH_LO,
      SEQ_RL_HI,
      SEQ_RL_LO,
      SEQ_WH_HI,
      SEQ_WH_LO,
      SEQ_WL_HI,
      SEQ_WL_LO
   } seq_state_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       panel;
      logic [7:0] value;
      logic       line;
      logic [4:0] column;
      logic [3:0] bus_in;
   } lcd_word_type;

   // same bit order as rsp_tdata[11:0]
   typedef struct packed {
      logic       tmo;
      logic       rej;
      logic       idle;
      logic       drive;
      logic [3:0] bus;
      logic       rw;
      logic       rs;
      logic       en_cu;
      logic       en_op;
   } pins_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [2:0]            req_tuser = REQ_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = CSR_ENABLE_HIGH;
   logic [15:0]           csr_data = '0;

   lcd_word_type pending[$];
   pins_type     exp_pins[$];
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_stall_pct = 0;
   int unsigned  mismatches = 0;
   bit           req_taken = 1'b0;

   // mirror of the sequencer
   logic [7:0]    cfg_hi, cfg_lo, cfg_rd;
   logic [15:0]   cfg_polls;
   seq_state_type seq_st;
   logic [7:0]    seq_ticks;
   logic [15:0]   polls_left;
   logic [7:0]    byte_q;
   logic          rs_q, panel_q, busy_q, timeout_q;

   char_lcd_4bit_sequencer DUT (.*);

   initial forever #6 clock = ~clock;

   function automatic int unsigned eff(logic [7:0] d);
      return (d == 8'd0) ? 1 : d;
   endfunction

   function automatic void enter_state(seq_state_type s);
      seq_st = s;
      seq_ticks = 8'd1;
   endfunction

   function automatic pins_type lcd_pins_after(lcd_word_type w);
      pins_type    p;
      logic        en;
      int unsigned len;
      p = '0;
      p.drive = 1'b1;
      en = 1'b0;
      if (w.kind == REQ_TICK) begin
         if (seq_st != SEQ_IDLE) begin
            case (seq_st)
               SEQ_RH_LO, SEQ_RL_LO: len = eff(cfg_rd);
               SEQ_WH_LO, SEQ_WL_LO: len = eff(cfg_lo);
               default:              len = eff(cfg_hi);
            endcase
            if (seq_ticks < len) begin
               seq_ticks = seq_ticks + 8'd1;
            end else begin
               case (seq_st)
                  SEQ_RH_HI: begin
                     busy_q = w.bus_in[3];
                     enter_state(SEQ_RH_LO);
                  end
                  SEQ_RH_LO: enter_state(SEQ_RL_HI);
                  SEQ_RL_HI: enter_state(SEQ_RL_LO);
                  SEQ_RL_LO: begin
                     if (busy_q && polls_left != 16'd0) begin
                        polls_left = polls_left - 16'd1;
                        enter_state(SEQ_RH_HI);
                     end else begin
                        if (busy_q) timeout_q = 1'b1;
                        enter_state(SEQ_WH_HI);
                     end
                  end
                  SEQ_WH_HI: enter_state(SEQ_WH_LO);
                  SEQ_WH_LO: enter_state(SEQ_WL_HI);
                  SEQ_WL_HI: enter_state(SEQ_WL_LO);
                  default: begin
                     seq_st = SEQ_IDLE;
                     seq_ticks = 8'd0;
                  end
               endcase
            end
         end
      end else if (w.kind <= REQ_INIT) begin
         if (seq_st != SEQ_IDLE) begin
            p.rej = 1'b1;
         end else begin
            panel_q = w.panel;
            if (w.kind == REQ_INIT) begin
               byte_q = {4'h0, w.value[3:0]};
               rs_q = 1'b0;
               enter_state(SEQ_WL_HI);
            end else begin
               if (w.kind == REQ_CURSOR)
                  byte_q = w.line ? {CURSOR_LINE1, w.column[3:0]}
                                  : (CURSOR_LINE0 | {3'b000, w.column});
               else
                  byte_q = w.value;
               rs_q = (w.kind == REQ_DATA);
               polls_left = cfg_polls;
               busy_q = 1'b0;
               timeout_q = 1'b0;
               enter_state(SEQ_RH_HI);
            end
         end
      end
      case (seq_st)
         SEQ_RH_HI, SEQ_RL_HI, SEQ_RH_LO, SEQ_RL_LO: begin
            p.rw = 1'b1;
            p.bus = 4'hF;
            p.drive = 1'b0;
            en = (seq_st == SEQ_RH_HI || seq_st == SEQ_RL_HI);
         end
         SEQ_WH_HI, SEQ_WH_LO: begin
            p.rs = rs_q;
            p.bus = byte_q[7:4];
            en = (seq_st == SEQ_WH_HI);
         end
         SEQ_WL_HI, SEQ_WL_LO: begin
            p.rs = rs_q;
            p.bus = byte_q[3:0];
            en = (seq_st == SEQ_WL_HI);
         end
         default: ;
      endcase
      p.en_op = en && !panel_q;
      p.en_cu = en && panel_q;
      p.idle = (seq_st == SEQ_IDLE);
      p.tmo = timeout_q;
      return p;
   endfunction

   function automatic lcd_word_type random_word(logic [2:0] kind);
      lcd_word_type w;
      w.kind = kind;
      w.panel = 1'($urandom_range(1));
      w.value = 8'($urandom_range(255));
      w.line = 1'($urandom_range(1));
      w.column = 5'($urandom_range(31));
      w.bus_in = 4'($urandom_range(15));
      return w;
   endfunction

   function automatic lcd_word_type directed_word(logic [2:0] kind, logic panel,
                                                  logic [7:0] value, logic line,
                                                  logic [4:0] column);
      lcd_word_type w;
      w = random_word(kind);
      w.panel = panel;
      w.value = value;
      w.line = line;
      w.column = column;
      return w;
   endfunction

   // D7 of each tick is set with the given odds
   task automatic push_ticks(input int unsigned n, input int unsigned d7_pct);
      lcd_word_type w;
      repeat (n) begin
         w = random_word(REQ_TICK);
         w.bus_in[3] = ($urandom_range(99) < d7_pct);
         pending.push_back(w);
      end
   endtask

   task automatic report(input string what, input int unsigned got, input int unsigned want);
      mismatches++;
      $display("%0t: %s got %0h expected %0h", $time, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [3:0] got,
                              input logic [3:0] want);
      if (got !== want) report(what, 32'(got), 32'(want));
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending.size() != 0 || req_tvalid || exp_pins.size() != 0);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [7:0] hi, lo, rd, input logic [15:0] polls,
                            input int budget, input int unsigned sidle, rstall);
      int           pushed;
      int unsigned  n;
      int unsigned  r;
      lcd_word_type w;
      // finish any transfer before touching the timing
      drain();
      while (seq_st != SEQ_IDLE) begin
         push_ticks(1, 0);
         drain();
      end
      write_csr(CSR_ENABLE_HIGH, {8'h00, hi});
      write_csr(CSR_ENABLE_LOW, {8'h00, lo});
      write_csr(CSR_READ_LOW, {8'h00, rd});
      write_csr(CSR_POLL_LIMIT, polls);
      @(posedge clock);
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      pushed = 0;
      while (pushed < budget) begin
         r = $urandom_range(99);
         if (r < 6) begin
            pending.push_back(random_word(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI))));
         end else if (r < 10) begin
            push_ticks(1, BUSY_PCT);
         end else begin
            w = random_word(3'($urandom_range(REQ_CMD, REQ_INIT)));
            if (w.kind == REQ_INIT)
               n = eff(cfg_hi) + eff(cfg_lo);
            else
               n = 2 * (eff(cfg_hi) + eff(cfg_rd)) + 2 * (eff(cfg_hi) + eff(cfg_lo));
            // cut some short so the next request lands mid-transfer
            if ($urandom_range(99) < 15) n = $urandom_range(n);
            pending.push_back(w);
            push_ticks(n + $urandom_range(2), BUSY_PCT);
            pushed += 1 + n;
         end
      end
   endtask

   always @(negedge clock) begin : drive
      lcd_word_type w;
      if (!req_tvalid || req_taken) begin
         if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            w = pending.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= w.kind;
            req_tdata <= {5'b00000, w.bus_in, w.column, w.line, w.value, w.panel};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : observe
      lcd_word_type w;
      pins_type     got;
      pins_type     want;
      if (reset) begin
         req_taken = 1'b0;
         cfg_hi = ENABLE_HIGH_RESET;
         cfg_lo = ENABLE_LOW_RESET;
         cfg_rd = READ_LOW_RESET;
         cfg_polls = POLL_LIMIT_RESET;
         seq_st = SEQ_IDLE;
         seq_ticks = 8'd0;
         polls_left = 16'd0;
         byte_q = 8'd0;
         rs_q = 1'b0;
         panel_q = 1'b0;
         busy_q = 1'b0;
         timeout_q = 1'b0;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLE_HIGH: cfg_hi = csr_data[7:0];
               CSR_ENABLE_LOW:  cfg_lo = csr_data[7:0];
               CSR_READ_LOW:    cfg_rd = csr_data[7:0];
               CSR_POLL_LIMIT:  cfg_polls = csr_data;
               default: ;
            endcase
         end
         if (req_taken) begin
            w.kind = req_tuser;
            w.panel = req_tdata[0];
            w.value = req_tdata[8:1];
            w.line = req_tdata[9];
            w.column = req_tdata[14:10];
            w.bus_in = req_tdata[18:15];
            exp_pins.push_back(lcd_pins_after(w));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = pins_type'(rsp_tdata[11:0]);
            if (exp_pins.size() == 0) begin
               report("unexpected word", 32'(got), 0);
            end else begin
               want = exp_pins.pop_front();
               check_field("enable_operator", 4'(got.en_op), 4'(want.en_op));
               check_field("enable_customer", 4'(got.en_cu), 4'(want.en_cu));
               check_field("reg_select", 4'(got.rs), 4'(want.rs));
               check_field("read_not_write", 4'(got.rw), 4'(want.rw));
               check_field("bus_out", got.bus, want.bus);
               check_field("bus_drive", 4'(got.drive), 4'(want.drive));
               check_field("idle", 4'(got.idle), 4'(want.idle));
               check_field("rejected", 4'(got.rej), 4'(want.rej));
               check_field("timed_out", 4'(got.tmo), 4'(want.tmo));
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL char_lcd_4bit_sequencer");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_csr(CSR_ENABLE_HIGH, 16'd1);
      write_csr(CSR_ENABLE_LOW, 16'd1);
      write_csr(CSR_READ_LOW, 16'd1);
      write_csr(CSR_POLL_LIMIT, 16'd0);
      @(posedge clock);
      // init nibble sends only the low four bits
      pending.push_back(directed_word(REQ_INIT, 1'b0, 8'hFF, 1'b0, 5'd0));
      push_ticks(2, 0);
      push_ticks(1, 100);
      pending.push_back(directed_word(REQ_UNUSED_HI, 1'b1, 8'hFF, 1'b1, 5'd31));
      // busy with no retries left: time out, then write anyway
      pending.push_back(directed_word(REQ_CMD, 1'b1, 8'hFF, 1'b0, 5'd0));
      push_ticks(2, 100);
      pending.push_back(directed_word(REQ_DATA, 1'b0, 8'h55, 1'b0, 5'd0));
      pending.push_back(directed_word(REQ_UNUSED_LO, 1'b0, 8'h00, 1'b0, 5'd0));
      push_ticks(6, 100);
      // init keeps the timeout flag
      pending.push_back(directed_word(REQ_INIT, 1'b1, 8'h00, 1'b0, 5'd0));
      push_ticks(2, 0);
      pending.push_back(directed_word(REQ_DATA, 1'b0, 8'h00, 1'b0, 5'd0));
      push_ticks(8, 0);
      pending.push_back(directed_word(REQ_CURSOR, 1'b1, 8'h00, 1'b1, 5'd31));
      push_ticks(8, 0);

      run_phase(8'd1, 8'd1, 8'd1, 16'd3, 120, 0, 0);
      run_phase(8'd2, 8'd1, 8'd3, 16'd0, 100, 88, 0);
      run_phase(8'd3, 8'd2, 8'd1, 16'd2, 100, 0, 88);
      run_phase(8'd1, 8'd3, 8'd2, 16'hFFFF, 100, 19, 19);
      run_phase(8'd0, 8'd0, 8'd0, 16'd1, 60, 19, 19);
      run_phase(8'd12, 8'd9, 8'd7, 16'd1, 1, 0, 0);
      run_phase(ENABLE_HIGH_RESET, ENABLE_LOW_RESET, READ_LOW_RESET, POLL_LIMIT_RESET,
                80, 0, 0);
      drain();
      repeat (10) @(posedge clock);
      if (exp_pins.size() != 0) report("missing words", exp_pins.size(), 0);
      if (mismatches == 0)
         $display("PASS char_lcd_4bit_sequencer");
      else
         $display("FAIL char_lcd_4bit_sequencer");
      $finish;
   end

endmodule
